[rtl/prime_lister_trial_division_macros.svh]
// Assertion macros for the prime lister RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef PRIME_LISTER_TRIAL_DIVISION_MACROS_SVH
`define PRIME_LISTER_TRIAL_DIVISION_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, held off while reset is low
`define PLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prime lister check failed");

// next-cycle implication, held off while reset is low
`define PLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prime lister check failed");

`else

`define PLR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/plr_pkg.sv]
// Shared types and constants for the prime lister.
// No dependencies; used by plr_div and the top level.
package plr_pkg;

    localparam int FIELD_BITS = 8;   // width of the limit and prime fields
    localparam int MIN_PRIME  = 2;   // first candidate and first divisor

    // status from the serial remainder unit
    typedef struct packed {
        logic done;       // one-cycle pulse, remainder is final
        logic rem_zero;   // remainder is zero (valid with done)
    } div_status_t;

endpackage

[rtl/prime_lister_trial_division.sv]
// Prime lister: one limit beat in, the primes 2..limit out, ascending, last one flagged.
// Each trial division starts the serial remainder unit, which shifts in the VALUE_BITS
// dividend bits one at a time and then reports the remainder; a composite then steps on
// to the next candidate, a prime is held as pending first. One limit at a time; limits
// 0 and 1 give no beats. One divider tries divisors 2..cand/2 in turn, up to the first hit.
// Reset (rst_n, async, active low) returns to idle with no prime pending or shown.
module prime_lister_trial_division #(
    parameter int VALUE_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           upper_limit_valid,
    output logic                           upper_limit_ready,
    input  logic [plr_pkg::FIELD_BITS-1:0] upper_limit,
    output logic                           prime_valid,
    input  logic                           prime_ready,
    output logic [plr_pkg::FIELD_BITS-1:0] prime_value,
    output logic                           last_prime
);

`include "prime_lister_trial_division_macros.svh"

    localparam int W = VALUE_BITS;

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;   // waiting for a limit beat
    localparam logic [2:0] ST_TEST  = 3'd1;   // next divisor, or candidate proven prime
    localparam logic [2:0] ST_WAIT  = 3'd2;   // serial remainder running
    localparam logic [2:0] ST_FOUND = 3'd3;   // candidate is prime, push older pending one out
    localparam logic [2:0] ST_NEXT  = 3'd4;   // step to the next candidate
    localparam logic [2:0] ST_FLUSH = 3'd5;   // hand the held prime out as the last one

    logic [2:0]   state_reg, state_next;
    logic [W-1:0] limit_reg, limit_next;
    logic [W-1:0] cand_reg,  cand_next;
    logic [W-1:0] div_reg,   div_next;

    // The newest prime is held back one step: only when another prime turns up,
    // or the candidates run out, do we know whether it is the final one.
    logic         pend_valid_reg, pend_valid_next;
    logic [W-1:0] pend_reg,       pend_next;

    // output register parts the sequencer from the consumer
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_value_reg, out_value_next;
    logic         out_last_reg,  out_last_next;

    logic                 out_free;
    logic [W-1:0]         half;
    logic [W-1:0]         limit_in;
    logic                 div_start;
    plr_pkg::div_status_t div_stat;

    assign limit_in = upper_limit[W-1:0];   // bits above VALUE_BITS are ignored
    assign half     = cand_reg >> 1;
    assign out_free = !out_valid_reg || prime_ready;

    // a divisor past cand/2 means no divisor hit: candidate is prime
    assign div_start = (state_reg == ST_TEST) && (div_reg <= half);

    plr_div #(
        .W (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cand_reg),
        .divisor  (div_reg),
        .status   (div_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        cand_next       = cand_reg;
        div_next        = div_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;

        if (out_valid_reg && prime_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (upper_limit_valid)
                begin
                    limit_next = limit_in;
                    cand_next  = W'(plr_pkg::MIN_PRIME);
                    div_next   = W'(plr_pkg::MIN_PRIME);
                    if (limit_in >= W'(plr_pkg::MIN_PRIME))
                        state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (div_start)
                    state_next = ST_WAIT;
                else
                    state_next = ST_FOUND;
            end
            ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.rem_zero)
                        state_next = ST_NEXT;       // composite
                    else
                    begin
                        div_next   = div_reg + W'(1);
                        state_next = ST_TEST;
                    end
                end
            end
            ST_FOUND:
            begin
                if (!pend_valid_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = cand_reg;
                    state_next      = ST_NEXT;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = pend_reg;
                    out_last_next  = 1'b0;
                    pend_next      = cand_reg;
                    state_next     = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (cand_reg == limit_reg)
                    state_next = ST_FLUSH;
                else
                begin
                    cand_next  = cand_reg + W'(1);
                    div_next   = W'(plr_pkg::MIN_PRIME);
                    state_next = ST_TEST;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        cand_reg      <= cand_next;
        div_reg       <= div_next;
        pend_reg      <= pend_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign upper_limit_ready = (state_reg == ST_IDLE);
    assign prime_valid       = out_valid_reg;
    assign prime_value       = plr_pkg::FIELD_BITS'(out_value_reg);
    assign last_prime        = out_last_reg;

    // a run always finds 2 before it can flush
    `PLR_ASSERT_NOW(a_flush_has_pending, clk, rst_n, state_reg == ST_FLUSH, pend_valid_reg)
    // the remainder unit only reports while the sequencer waits on it
    `PLR_ASSERT_NOW(a_div_done_in_wait, clk, rst_n, div_stat.done, state_reg == ST_WAIT)
    // every shown beat is a real candidate
    `PLR_ASSERT_NOW(a_out_min_prime, clk, rst_n, out_valid_reg,
        out_value_reg >= W'(plr_pkg::MIN_PRIME))
    // divisor never runs past cand/2 + 1 while testing
    `PLR_ASSERT_NOW(a_div_range, clk, rst_n, state_reg == ST_TEST,
        (div_reg >= W'(plr_pkg::MIN_PRIME)) && (div_reg <= half + W'(1)))

endmodule

[rtl/plr_div.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on plr_pkg (div_status_t).
module plr_div #(
    parameter int W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [W-1:0]        dividend,
    input  logic [W-1:0]        divisor,
    output plr_pkg::div_status_t status
);

    localparam int CW = $clog2(W + 1);

    logic [W:0]    rem_reg,  rem_next;
    logic [W-1:0]  dsh_reg,  dsh_next;
    logic [W-1:0]  dvs_reg,  dvs_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg[W-1:0], dsh_reg[W-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dsh_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
                rem_next = trial - {1'b0, dvs_reg};
            else
                rem_next = trial;
            dsh_next = {dsh_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        dvs_reg <= dvs_next;
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule
